// ----- hdl/sop_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sop_pkg
// Shared types and constants of the slab object allocator.
// ----------------------------------------------------------------------------
package sop_pkg;

  // defaults for the top-level parameters
  localparam int unsigned CacheDepthDef = 64;
  localparam int unsigned BatchSizeDef  = 16;

  // handle layout: page * SlotsMax + slot
  localparam int unsigned PageCount = 16;
  localparam int unsigned SlotsMax  = 64;
  localparam int unsigned HandleW   = 10;
  localparam int unsigned SlotW     = $clog2(SlotsMax);
  localparam int unsigned PageW     = $clog2(PageCount);
  localparam int unsigned PageIdW   = PageW + 1;
  localparam logic [PageIdW-1:0] NilPage = PageIdW'(PageCount);

  localparam int unsigned SppW = SlotW + 1;
  localparam logic [SppW-1:0] SppReset = SppW'(32);
  localparam logic [SppW-1:0] SppMax   = SppW'(SlotsMax);
  localparam logic [SppW-1:0] SppMin   = SppW'(1);

  localparam int unsigned ActiveW = 11;
  localparam logic [ActiveW-1:0] ActiveMax = '1;

  // slot bitmap is searched one chunk per cycle
  localparam int unsigned ScanLog = 3;
  localparam int unsigned ScanW   = 1 << ScanLog;
  localparam int unsigned ChunkW  = SlotW - ScanLog;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic RegSlotsPerPage = 1'b0;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } sop_op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_PAGE    = 2'd1,
    ST_BAD_HANDLE = 2'd2
  } sop_status_e;

  typedef enum logic [1:0] {
    SRC_CACHE   = 2'd0,
    SRC_PARTIAL = 2'd1,
    SRC_NEW     = 2'd2,
    SRC_NONE    = 2'd3
  } sop_source_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CPOP,
    S_WALK,
    S_SCAN,
    S_NEW,
    S_FCHK,
    S_BREAD,
    S_BRET,
    S_BCHK,
    S_PUSH,
    S_FIN
  } sop_state_e;

  typedef struct packed {
    logic               opcode;
    logic [HandleW-1:0] object_handle;
  } sop_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         source;
    logic [HandleW-1:0] granted_handle;
    logic [4:0]         returned_count;
    logic [4:0]         pages_reclaimed;
    logic [ActiveW-1:0] active_objects;
    logic [ActiveW-1:0] peak_objects;
    logic [6:0]         cache_fill;
  } sop_rsp_t;

  // classified command between front and back
  typedef struct packed {
    logic               is_free;
    logic               slot_ok;
    logic [HandleW-1:0] handle;
  } sop_cmd_t;

endpackage
`default_nettype wire

// ----- hdl/sop_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sop_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sop_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- hdl/sop_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sop_front
// Register port and request classification.
// ----------------------------------------------------------------------------
module sop_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sop_pkg::CfgAddrW-1:0]   paddr,
  input  wire logic [sop_pkg::CfgDataW-1:0]   pwdata,
  output logic      [sop_pkg::CfgDataW-1:0]   prdata,
  output logic                                pready,
  input  wire logic                           used_any_i,
  input  wire sop_pkg::sop_req_t              req_i,
  output sop_pkg::sop_cmd_t                   cmd_o,
  output logic      [sop_pkg::SppW-1:0]       spp_o
);
  import sop_pkg::*;

  logic [SppW-1:0] spp_q, spp_d;
  logic [SppW-1:0] wval;
  logic            reg_sel;

  assign reg_sel = (paddr[CfgAddrW-1] == RegSlotsPerPage);
  assign wval    = pwdata[SppW-1:0];
  assign pready  = 1'b1;

  always_comb begin
    spp_d = spp_q;
    // geometry may change only while no page is in use
    if (psel && penable && pwrite && reg_sel && !used_any_i) begin
      if (wval == '0) begin
        spp_d = SppMin;
      end else if (wval > SppMax) begin
        spp_d = SppMax;
      end else begin
        spp_d = wval;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spp_q <= SppReset;
    end else begin
      spp_q <= spp_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel && paddr[CfgAddrW-2:0] == '0) begin
      prdata = CfgDataW'(spp_q);
    end
  end

  assign spp_o         = spp_q;
  assign cmd_o.is_free = (req_i.opcode == OP_FREE);
  assign cmd_o.handle  = req_i.object_handle;
  assign cmd_o.slot_ok = ({1'b0, req_i.object_handle[SlotW-1:0]} < spp_q);

endmodule
`default_nettype wire

// ----- hdl/sop_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sop_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module sop_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_valid_i,
  output logic                   wr_ready_o,
  input  wire sop_pkg::sop_cmd_t wr_data_i,
  output logic                   rd_valid_o,
  input  wire logic              rd_ready_i,
  output sop_pkg::sop_cmd_t      rd_data_o
);
  import sop_pkg::*;

  sop_cmd_t   buf_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = buf_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sop_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sop_back
// Allocation/free sequencer: free cache, page list, bitmaps, result register.
// ----------------------------------------------------------------------------
module sop_back #(
  parameter int unsigned CacheDepth = sop_pkg::CacheDepthDef,
  parameter int unsigned BatchSize  = sop_pkg::BatchSizeDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cmd_valid_i,
  output logic                          cmd_ready_o,
  input  wire sop_pkg::sop_cmd_t        cmd_i,
  input  wire logic [sop_pkg::SppW-1:0] spp_i,
  output logic                          used_any_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output sop_pkg::sop_rsp_t             out_data_o
);
  import sop_pkg::*;

  localparam int unsigned AddrW = $clog2(CacheDepth);
  localparam int unsigned CntW  = $clog2(CacheDepth + 1);
  localparam int unsigned RetW  = $clog2(BatchSize + 1);

  sop_state_e state_q, state_d;

  logic [SlotsMax-1:0] bitmap_q [PageCount];
  logic [SlotsMax-1:0] bitmap_d [PageCount];
  logic [SppW-1:0]     free_q   [PageCount];
  logic [SppW-1:0]     free_d   [PageCount];
  logic [PageIdW-1:0]  next_q   [PageCount];
  logic [PageIdW-1:0]  next_d   [PageCount];
  logic [PageIdW-1:0]  prev_q   [PageCount];
  logic [PageIdW-1:0]  prev_d   [PageCount];
  logic [PageCount-1:0] used_q, used_d;
  logic [PageIdW-1:0]  head_q, head_d, tail_q, tail_d;

  logic [CntW-1:0]    count_q, count_d, idx_q, idx_d;
  logic               pend_q, pend_d;
  logic [ActiveW-1:0] active_q, active_d, peak_q, peak_d;
  logic [PageIdW-1:0] pg_q, pg_d;
  logic [PageIdW-1:0] guard_q, guard_d;
  logic [ChunkW-1:0]  chunk_q, chunk_d;
  logic [HandleW-1:0] h_q, h_d, hret_q, hret_d;
  logic               is_free_q, is_free_d;
  logic [RetW-1:0]    ret_q, ret_d, recl_q, recl_d;
  logic [1:0]         status_q, status_d, source_q, source_d;
  logic [HandleW-1:0] grant_q, grant_d;

  logic     out_valid_q, out_valid_d;
  sop_rsp_t out_data_q, out_data_d;

  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr, ram_raddr;
  logic [HandleW-1:0] ram_rdata;

  sop_ram #(
    .Width (HandleW),
    .Depth (CacheDepth)
  ) u_cache (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (h_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // scratch for the combinational block
  logic [PageW-1:0]   pidx, cpg, rpg;
  logic [SlotW-1:0]   cslot;
  logic [ScanW-1:0]   chunk_bits, cand;
  logic [ScanLog-1:0] low;
  logic               found, page_found, issue, load;
  logic [PageW-1:0]   new_pg;
  logic [PageIdW-1:0] rm_pv, rm_nx;
  logic [SppW-1:0]    new_free;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign used_any_o  = |used_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d   = state_q;
    bitmap_d  = bitmap_q;
    free_d    = free_q;
    next_d    = next_q;
    prev_d    = prev_q;
    used_d    = used_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pend_d    = 1'b0;
    active_d  = active_q;
    peak_d    = peak_q;
    pg_d      = pg_q;
    guard_d   = guard_q;
    chunk_d   = chunk_q;
    h_d       = h_q;
    hret_d    = hret_q;
    is_free_d = is_free_q;
    ret_d     = ret_q;
    recl_d    = recl_q;
    status_d  = status_q;
    source_d  = source_q;
    grant_d   = grant_q;
    ram_we    = 1'b0;
    ram_waddr = count_q[AddrW-1:0];
    ram_raddr = idx_q[AddrW-1:0];
    load      = 1'b0;
    out_data_d = out_data_q;

    pidx  = pg_q[PageW-1:0];
    cpg   = cmd_i.handle[HandleW-1:SlotW];
    cslot = cmd_i.handle[SlotW-1:0];
    rpg   = hret_q[HandleW-1:SlotW];
    issue = 1'b0;
    rm_pv = NilPage;
    rm_nx = NilPage;
    new_free = '0;

    chunk_bits = bitmap_q[pidx][chunk_q*ScanW +: ScanW];
    for (int j = 0; j < ScanW; j++) begin
      cand[j] = !chunk_bits[j] && ({1'b0, chunk_q, ScanLog'(j)} < spp_i);
    end
    found = |cand;
    low   = '0;
    for (int j = ScanW - 1; j >= 0; j--) begin
      if (cand[j]) low = ScanLog'(j);
    end

    page_found = 1'b0;
    new_pg     = '0;
    for (int p = PageCount - 1; p >= 0; p--) begin
      if (!used_q[p]) begin
        page_found = 1'b1;
        new_pg     = PageW'(p);
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          h_d       = cmd_i.handle;
          is_free_d = cmd_i.is_free;
          ret_d     = '0;
          recl_d    = '0;
          status_d  = ST_OK;
          source_d  = SRC_NONE;
          grant_d   = '0;
          if (!cmd_i.is_free) begin
            if (count_q != '0) begin
              ram_raddr = AddrW'(count_q - CntW'(1));
              count_d   = count_q - CntW'(1);
              state_d   = S_CPOP;
            end else begin
              pg_d    = head_q;
              guard_d = '0;
              state_d = S_WALK;
            end
          end else if (int'(cpg) < PageCount && used_q[cpg] && cmd_i.slot_ok &&
                       bitmap_q[cpg][cslot]) begin
            idx_d   = '0;
            state_d = S_FCHK;
          end else begin
            status_d = ST_BAD_HANDLE;
            state_d  = S_FIN;
          end
        end
      end

      S_CPOP: begin
        grant_d  = ram_rdata;
        source_d = SRC_CACHE;
        state_d  = S_FIN;
      end

      S_WALK: begin
        if (pg_q == NilPage || guard_q == PageIdW'(PageCount)) begin
          state_d = S_NEW;
        end else if (free_q[pidx] != '0) begin
          chunk_d = '0;
          state_d = S_SCAN;
        end else begin
          pg_d    = next_q[pidx];
          guard_d = guard_q + PageIdW'(1);
        end
      end

      S_SCAN: begin
        if (found) begin
          bitmap_d[pidx][{chunk_q, low}] = 1'b1;
          free_d[pidx] = free_q[pidx] - SppW'(1);
          if (free_q[pidx] == SppW'(1)) begin
            rm_pv = prev_q[pidx];
            rm_nx = next_q[pidx];
            if (rm_pv != NilPage) next_d[rm_pv[PageW-1:0]] = rm_nx;
            else head_d = rm_nx;
            if (rm_nx != NilPage) prev_d[rm_nx[PageW-1:0]] = rm_pv;
            else tail_d = rm_pv;
            next_d[pidx] = NilPage;
            prev_d[pidx] = NilPage;
          end
          grant_d  = {pidx, chunk_q, low};
          source_d = SRC_PARTIAL;
          state_d  = S_FIN;
        end else if ({1'b0, chunk_q, {ScanLog{1'b1}}} >= spp_i - SppW'(1)) begin
          // no usable slot left in this page
          pg_d    = next_q[pidx];
          guard_d = guard_q + PageIdW'(1);
          state_d = S_WALK;
        end else begin
          chunk_d = chunk_q + ChunkW'(1);
        end
      end

      S_NEW: begin
        if (page_found) begin
          used_d[new_pg]   = 1'b1;
          bitmap_d[new_pg] = SlotsMax'(1);
          new_free         = spp_i - SppW'(1);
          free_d[new_pg]   = new_free;
          if (new_free != '0) begin
            next_d[new_pg] = NilPage;
            prev_d[new_pg] = tail_q;
            if (tail_q != NilPage) next_d[tail_q[PageW-1:0]] = {1'b0, new_pg};
            else head_d = {1'b0, new_pg};
            tail_d = {1'b0, new_pg};
          end
          grant_d  = {new_pg, SlotW'(0)};
          source_d = SRC_NEW;
        end else begin
          status_d = ST_NO_PAGE;
        end
        state_d = S_FIN;
      end

      // duplicate check: one cache entry per cycle, read pipelined
      S_FCHK: begin
        issue = (idx_q < count_q);
        if (issue) idx_d = idx_q + CntW'(1);
        pend_d = issue;
        if (pend_q && ram_rdata == h_q) begin
          status_d = ST_BAD_HANDLE;
          state_d  = S_FIN;
        end else if (!issue && !pend_q) begin
          if (count_q >= CntW'(CacheDepth)) state_d = S_BREAD;
          else state_d = S_PUSH;
        end
      end

      S_BREAD: begin
        ram_raddr = AddrW'(count_q - CntW'(1));
        count_d   = count_q - CntW'(1);
        state_d   = S_BRET;
      end

      S_BRET: begin
        hret_d = ram_rdata;
        cpg    = ram_rdata[HandleW-1:SlotW];
        cslot  = ram_rdata[SlotW-1:0];
        bitmap_d[cpg][cslot] = 1'b0;
        free_d[cpg] = free_q[cpg] + SppW'(1);
        if (free_q[cpg] == '0) begin
          next_d[cpg] = NilPage;
          prev_d[cpg] = tail_q;
          if (tail_q != NilPage) next_d[tail_q[PageW-1:0]] = {1'b0, cpg};
          else head_d = {1'b0, cpg};
          tail_d = {1'b0, cpg};
        end
        ret_d   = ret_q + RetW'(1);
        state_d = S_BCHK;
      end

      S_BCHK: begin
        // a wholly free page goes back unless it is the only listed one
        if (free_q[rpg] == spp_i && head_q != tail_q) begin
          rm_pv = prev_q[rpg];
          rm_nx = next_q[rpg];
          if (rm_pv != NilPage) next_d[rm_pv[PageW-1:0]] = rm_nx;
          else head_d = rm_nx;
          if (rm_nx != NilPage) prev_d[rm_nx[PageW-1:0]] = rm_pv;
          else tail_d = rm_pv;
          next_d[rpg]   = NilPage;
          prev_d[rpg]   = NilPage;
          bitmap_d[rpg] = '0;
          free_d[rpg]   = '0;
          used_d[rpg]   = 1'b0;
          recl_d        = recl_q + RetW'(1);
        end
        if (ret_q < RetW'(BatchSize) && count_q != '0) state_d = S_BREAD;
        else state_d = S_PUSH;
      end

      S_PUSH: begin
        if (count_q < CntW'(CacheDepth)) begin
          ram_we  = 1'b1;
          count_d = count_q + CntW'(1);
        end
        state_d = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          load = 1'b1;
          if (status_q == ST_OK) begin
            if (is_free_q) begin
              if (active_q != '0) active_d = active_q - ActiveW'(1);
            end else begin
              if (active_q != ActiveMax) active_d = active_q + ActiveW'(1);
              if (active_d > peak_q) peak_d = active_d;
            end
          end
          out_data_d.status          = status_q;
          out_data_d.source          = source_q;
          out_data_d.granted_handle  = grant_q;
          out_data_d.returned_count  = 5'(ret_q);
          out_data_d.pages_reclaimed = 5'(recl_q);
          out_data_d.active_objects  = active_d;
          out_data_d.peak_objects    = peak_d;
          out_data_d.cache_fill      = 7'(count_q);
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    out_valid_d = out_valid_q && !out_ready_i;
    if (load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int p = 0; p < PageCount; p++) begin
        bitmap_q[p] <= '0;
        free_q[p]   <= '0;
        next_q[p]   <= NilPage;
        prev_q[p]   <= NilPage;
      end
      used_q      <= '0;
      head_q      <= NilPage;
      tail_q      <= NilPage;
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      active_q    <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bitmap_q    <= bitmap_d;
      free_q      <= free_d;
      next_q      <= next_d;
      prev_q      <= prev_d;
      used_q      <= used_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      active_q    <= active_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pg_q       <= pg_d;
    guard_q    <= guard_d;
    chunk_q    <= chunk_d;
    h_q        <= h_d;
    hret_q     <= hret_d;
    is_free_q  <= is_free_d;
    ret_q      <= ret_d;
    recl_q     <= recl_d;
    status_q   <= status_d;
    source_q   <= source_d;
    grant_q    <= grant_d;
    out_data_q <= out_data_d;
  end

endmodule
`default_nettype wire

// ----- hdl/slab_object_allocator_unit.sv -----
// Path from input transfer to result: a cache alloc pops the free cache; a list alloc
// walks the list pages and scans each in 8-slot chunks; otherwise a new page is taken.
// Free: a bad handle is rejected; an accepted one is checked against every cached
// handle and pushed, and a full cache first returns up to 16 handles to their pages.
// One item in work at a time; the next starts the cycle after its result loads.
// Reset: asynchronous, clears all control and page state at once; no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// slab_object_allocator_unit
// Slab object allocator with a LIFO free cache and a partial-page list.
// ----------------------------------------------------------------------------
module slab_object_allocator_unit #(
  parameter int unsigned CacheDepth = sop_pkg::CacheDepthDef,
  parameter int unsigned BatchSize  = sop_pkg::BatchSizeDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sop_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [sop_pkg::CfgDataW-1:0] pwdata,
  output logic      [sop_pkg::CfgDataW-1:0] prdata,
  output logic                              pready,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire sop_pkg::sop_req_t            in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output sop_pkg::sop_rsp_t                 out_data_o
);
  import sop_pkg::*;

  sop_cmd_t        cmd_in, cmd_out;
  logic            q_valid, q_ready, used_any;
  logic [SppW-1:0] spp;

  sop_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .used_any_i (used_any),
    .req_i      (in_data_i),
    .cmd_o      (cmd_in),
    .spp_o      (spp)
  );

  sop_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (in_valid_i),
    .wr_ready_o (in_ready_o),
    .wr_data_i  (cmd_in),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (cmd_out)
  );

  sop_back #(
    .CacheDepth (CacheDepth),
    .BatchSize  (BatchSize)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (cmd_out),
    .spp_i       (spp),
    .used_any_o  (used_any),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ----- hdl/sop_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sop_checker
// Port-level checks of the slab object allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sop_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sop_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [sop_pkg::CfgDataW-1:0] pwdata,
  input  wire logic [sop_pkg::CfgDataW-1:0] prdata,
  input  wire logic                         pready,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_ready_o,
  input  wire sop_pkg::sop_req_t            in_data_i,
  input  wire logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  input  wire sop_pkg::sop_rsp_t            out_data_o
);
  import sop_pkg::*;

  // result held until transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped before transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_BAD_HANDLE |->
      out_data_o.source == SRC_NONE && out_data_o.granted_handle == '0 &&
      out_data_o.returned_count == '0)
    else $error("rejected free changed state fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.source != SRC_NONE |->
      out_data_o.returned_count == '0 && out_data_o.pages_reclaimed == '0)
    else $error("allocation reported returned handles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.peak_objects >= out_data_o.active_objects &&
      out_data_o.pages_reclaimed <= out_data_o.returned_count)
    else $error("peak below active or reclaim count too high");

endmodule

bind slab_object_allocator_unit sop_checker u_sop_checker (.*);
`default_nettype wire

// ----- tb/sv/tb_slab_object_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// tb_slab_object_allocator_unit
// Self-checking bench for the slab allocator: a queue-fed driver offers
// alloc/free requests, a shadow allocator predicts every response and a
// monitor compares each response field by field under random back-pressure.
// ----------------------------------------------------------------------------
module tb_slab_object_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sop_pkg::*;

  typedef struct {
    sop_req_t req;
    sop_rsp_t rsp;
  } job_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sop_req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  sop_rsp_t out_data_o;

  slab_object_allocator_unit uut (.*);

  always #10 clk_i = ~clk_i;

  // shadow allocator state
  logic [HandleW-1:0] sh_cache[64];
  int sh_fill, sh_spp, sh_active, sh_peak, sh_head, sh_tail;
  logic [63:0] sh_bmap[16];
  int sh_fslots[16], sh_next[16], sh_prev[16];
  logic [15:0] sh_used;

  job_t pending_q[$];
  sop_rsp_t rsp_q[$];
  job_t cur_job;
  int live_q[$];
  int send_idle_pct = 0, recv_idle_pct = 0, hold_cycles = 0;
  int errors = 0, n_frees = 0, n_allocs = 0, n_batches = 0, n_nopage = 0;
  int cycles = 0;

  function automatic void page_unlink(int p);
    if (sh_prev[p] < 16) sh_next[sh_prev[p]] = sh_next[p]; else sh_head = sh_next[p];
    if (sh_next[p] < 16) sh_prev[sh_next[p]] = sh_prev[p]; else sh_tail = sh_prev[p];
    sh_next[p] = 16;
    sh_prev[p] = 16;
  endfunction

  function automatic void page_link(int p);
    sh_next[p] = 16;
    sh_prev[p] = sh_tail;
    if (sh_tail < 16) sh_next[sh_tail] = p; else sh_head = p;
    sh_tail = p;
  endfunction

  function automatic void set_spp(int v);
    v = v & 8'h7F;
    if (sh_used != 0) return;
    if (v == 0) v = 1;
    if (v > 64) v = 64;
    sh_spp = v;
  endfunction

  function automatic sop_rsp_t alloc_predict(sop_req_t rq);
    sop_rsp_t r;
    int p, s, g, h;
    bit done, ok;
    r = '0;
    r.status = ST_OK;
    r.source = SRC_NONE;
    done = 0;
    if (sop_op_e'(rq.opcode) == OP_ALLOC) begin
      if (sh_fill > 0) begin
        sh_fill--;
        r.granted_handle = sh_cache[sh_fill];
        r.source = SRC_CACHE;
        done = 1;
      end
      p = sh_head;
      for (g = 0; g < 16 && p < 16 && !done; g++) begin
        if (sh_fslots[p] > 0) begin
          for (s = 0; s < sh_spp && !done; s++) begin
            if (!sh_bmap[p][s]) begin
              sh_bmap[p][s] = 1'b1;
              sh_fslots[p]--;
              if (sh_fslots[p] == 0) page_unlink(p);
              r.granted_handle = HandleW'(p * 64 + s);
              r.source = SRC_PARTIAL;
              done = 1;
            end
          end
        end
        if (!done) p = sh_next[p];
      end
      for (p = 0; p < 16 && !done; p++) begin
        if (!sh_used[p]) begin
          sh_used[p] = 1'b1;
          sh_bmap[p] = 64'd1;
          sh_fslots[p] = sh_spp - 1;
          if (sh_fslots[p] > 0) page_link(p);
          r.granted_handle = HandleW'(p * 64);
          r.source = SRC_NEW;
          done = 1;
        end
      end
      if (done) begin
        if (sh_active < 2047) sh_active++;
        if (sh_active > sh_peak) sh_peak = sh_active;
      end else begin
        r.status = ST_NO_PAGE;
      end
    end else begin
      h = rq.object_handle;
      p = h / 64;
      s = h % 64;
      ok = sh_used[p] && s < sh_spp && sh_bmap[p][s];
      for (g = 0; g < sh_fill; g++) if (sh_cache[g] == h) ok = 0;
      if (!ok) begin
        r.status = ST_BAD_HANDLE;
      end else begin
        if (sh_fill >= 64) begin
          for (g = 0; g < 16 && sh_fill > 0; g++) begin
            int rh, rp;
            bit pg_was_packed;
            sh_fill--;
            rh = sh_cache[sh_fill];
            rp = rh / 64;
            pg_was_packed = (sh_fslots[rp] == 0);
            sh_bmap[rp][rh % 64] = 1'b0;
            sh_fslots[rp]++;
            if (pg_was_packed) page_link(rp);
            if (sh_fslots[rp] == sh_spp && sh_head != sh_tail) begin
              page_unlink(rp);
              sh_bmap[rp] = '0;
              sh_fslots[rp] = 0;
              sh_used[rp] = 1'b0;
              r.pages_reclaimed++;
            end
            r.returned_count++;
          end
        end
        if (sh_fill < 64) begin
          sh_cache[sh_fill] = HandleW'(h);
          sh_fill++;
        end
        if (sh_active > 0) sh_active--;
      end
    end
    r.active_objects = ActiveW'(sh_active);
    r.peak_objects = ActiveW'(sh_peak);
    r.cache_fill = 7'(sh_fill);
    return r;
  endfunction

  // predict now (acceptance order equals queue order) and track live handles
  function automatic void push_req(bit is_free, int h);
    job_t j;
    int k;
    j.req.opcode = is_free ? OP_FREE : OP_ALLOC;
    j.req.object_handle = HandleW'(h);
    j.rsp = alloc_predict(j.req);
    if (j.rsp.status == ST_OK) begin
      if (!is_free) begin
        live_q.push_back(j.rsp.granted_handle);
        n_allocs++;
      end else begin
        n_frees++;
        if (j.rsp.returned_count != 0) n_batches++;
        for (k = 0; k < live_q.size(); k++)
          if (live_q[k] == h) begin
            live_q.delete(k);
            break;
          end
      end
    end
    if (j.rsp.status == ST_NO_PAGE) n_nopage++;
    pending_q.push_back(j);
  endfunction

  function automatic void push_random(int alloc_pct);
    int r, k, h;
    r = $urandom_range(99);
    if (r < alloc_pct) begin
      push_req(0, $urandom_range(1023));
    end else begin
      r = $urandom_range(99);
      if (r < 75 && live_q.size() > 0) begin
        k = $urandom_range(live_q.size() - 1);
        h = live_q[k];
      end else if (r < 85 && sh_fill > 0) begin
        h = sh_cache[$urandom_range(sh_fill - 1)];
      end else begin
        h = $urandom_range(1023);
      end
      push_req(1, h);
    end
  endfunction

  task automatic cfg_write(logic [CfgAddrW-1:0] a, logic [CfgDataW-1:0] d);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (a == 0) set_spp(d);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i || rsp_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic run_phase(int sidle, int ridle, int count, bit long_hold);
    int i;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    if (long_hold) hold_cycles = 600;
    for (i = 0; i < count; i++) push_random(((i / 90) % 2) ? 25 : 80);
    drain();
  endtask

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) rsp_q.push_back(cur_job.rsp);
    if (!in_valid_i || in_ready_o) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_job = pending_q.pop_front();
        in_valid_i <= 1'b1;
        in_data_i <= cur_job.req;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // monitor and receiver back-pressure
  always @(posedge clk_i) begin
    sop_rsp_t e;
    cycles++;
    if (cycles > 3000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
    if (out_valid_o && out_ready_i) begin
      if (rsp_q.size() == 0) begin
        $error("response transfer with nothing expected");
        errors++;
      end else begin
        e = rsp_q.pop_front();
        check_field("status", e.status, out_data_o.status);
        check_field("source", e.source, out_data_o.source);
        check_field("granted_handle", e.granted_handle, out_data_o.granted_handle);
        check_field("returned_count", e.returned_count, out_data_o.returned_count);
        check_field("pages_reclaimed", e.pages_reclaimed, out_data_o.pages_reclaimed);
        check_field("active_objects", e.active_objects, out_data_o.active_objects);
        check_field("peak_objects", e.peak_objects, out_data_o.peak_objects);
        check_field("cache_fill", e.cache_fill, out_data_o.cache_fill);
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    int p;
    sh_fill = 0; sh_active = 0; sh_peak = 0; sh_spp = 32;
    sh_head = 16; sh_tail = 16; sh_used = '0;
    for (p = 0; p < 16; p++) begin
      sh_bmap[p] = '0; sh_fslots[p] = 0; sh_next[p] = 16; sh_prev[p] = 16;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // out-of-range values clamp; the last write sets the working page size
    cfg_write(0, 32'h7F);
    cfg_write(0, 32'h0);
    cfg_write(4, 32'h5);
    cfg_write(0, 32'hFFFF_FF08);
    // directed: new page, partial page, cache pop and every bad-handle kind
    push_req(0, 1023);
    push_req(0, 0);
    push_req(0, 512);
    push_req(1, 1);
    push_req(0, 0);
    push_req(1, 1023);
    push_req(1, 5 * 64);
    push_req(1, 9);
    push_req(1, 7);
    push_req(1, 2);
    push_req(1, 2);
    push_req(1, 0);
    push_req(0, 0);
    push_req(0, 0);
    drain();
    run_phase(10, 77, 520, 1);
    cfg_write(0, 32'd64);  // pages in use: ignored
    run_phase(77, 10, 520, 0);
    cfg_write(0, 32'd1);
    run_phase(0, 0, 520, 0);
    $display("covered %0d allocs, %0d frees, %0d batch returns, %0d out-of-page allocs",
             n_allocs, n_frees, n_batches, n_nopage);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/sop_pkg.sv
hdl/sop_ram.sv
hdl/sop_front.sv
hdl/sop_queue.sv
hdl/sop_back.sv
hdl/slab_object_allocator_unit.sv
hdl/sop_checker.sv
tb/sv/tb_slab_object_allocator_unit.sv
